// ===== src/fetc_pkg.sv =====
// Shared types, codes and defaults for the first-edge timestamp capture block.
`default_nettype none

package fetc_pkg;

  // Default geometry
  localparam int CHANNELS_DEF   = 32;
  localparam int CLOCK_BITS_DEF = 48;

  // Fixed field widths
  localparam int SAMPLE_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SECONDS_W  = 16;
  localparam int SKIP_W     = 16;

  typedef logic [47:0] clk_out_t;
  typedef logic [4:0]  chan_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FINISHED_MASK   = 2'd0,
    REG_SKIP_COUNT      = 2'd1,
    REG_TIMEOUT_SECONDS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                is_tick;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    chan_t               channel;
    clk_out_t            edge_clock;
    logic                edge_seen;
    logic [SAMPLE_W-1:0] first_sample;
    logic [SAMPLE_W-1:0] last_sample;
    clk_out_t            end_clock;
    logic                timeout_hit;
    logic                last;
  } out_item_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic capture;  // data sample after the reference: look for first toggles
    logic shift;    // report transaction taken: move contents one cell down
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/fetc_cell.sv =====
// One channel cell: first-toggle detect, timestamp hold and report shift.
`default_nettype none

module fetc_cell #(
  parameter int CLOCK_BITS = fetc_pkg::CLOCK_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fetc_pkg::cell_ctrl_t   ctrl,
  input  wire logic                   sample_bit,
  input  wire logic                   prev_bit,
  input  wire logic [CLOCK_BITS-1:0]  clock_in,
  input  wire logic [CLOCK_BITS-1:0]  shift_edge_in,
  input  wire logic                   shift_done_in,
  output logic [CLOCK_BITS-1:0]       edge_time_r,
  output logic                        done_r,
  output logic                        done_nxt
);

  logic                  fresh;
  logic [CLOCK_BITS-1:0] edge_time_nxt;

  // Detect the first toggle of this channel
  assign fresh = ctrl.capture & (sample_bit ^ prev_bit) & ~done_r;

  always_comb begin
    edge_time_nxt = edge_time_r;
    done_nxt      = done_r;
    if (ctrl.shift) begin
      edge_time_nxt = shift_edge_in;
      done_nxt      = shift_done_in;
    end else if (fresh) begin
      edge_time_nxt = clock_in;
      done_nxt      = 1'b1;
    end
  end

  // Hold timestamp and seen flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_time_r <= '0;
      done_r      <= 1'b0;
    end else begin
      edge_time_r <= edge_time_nxt;
      done_r      <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/first_edge_timestamp_capture.sv =====
// Top level: sample sequencing, timeout, report control over a row of channel cells.
// Latency: the first report transaction is valid in the cycle after the triggering item.
// Throughput: one input item per cycle while capturing; the cell update sets this.
//   The report then gives CHANNELS transactions, at most one per cycle.
// Input is stalled while the report is out; afterwards items are taken and dropped.
// Reset (rst_n low, synchronous) clears all timestamps and run state; no clearing pass.
`default_nettype none

module first_edge_timestamp_capture #(
  parameter int CHANNELS   = fetc_pkg::CHANNELS_DEF,
  parameter int CLOCK_BITS = fetc_pkg::CLOCK_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire fetc_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output fetc_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [fetc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [fetc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CntW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW   = fetc_pkg::SAMPLE_W;
  localparam int SecW = fetc_pkg::SECONDS_W;
  localparam int SkW  = fetc_pkg::SKIP_W;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_REPORT,
    ST_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic [SW-1:0]         finished_mask_r, finished_mask_nxt;
  logic [SecW-1:0]       timeout_r, timeout_nxt;
  logic [SkW-1:0]        skip_left_r, skip_left_nxt;
  logic                  have_ref_r, have_ref_nxt;
  logic [SW-1:0]         ref_sample_r, ref_sample_nxt;
  logic [SW-1:0]         prev_sample_r, prev_sample_nxt;
  logic [CLOCK_BITS-1:0] sample_clock_r, sample_clock_nxt;
  logic [SecW-1:0]       seconds_r, seconds_nxt;
  logic                  timeout_flag_r, timeout_flag_nxt;

  fetc_pkg::cell_ctrl_t  ctrl;
  logic                  in_accept;
  logic                  out_accept;
  logic                  check;
  logic                  all_done;
  logic [CHANNELS-1:0]   done_nxt_vec;

  logic [CLOCK_BITS-1:0] edge_chain [CHANNELS];
  logic                  done_chain [CHANNELS];

  assign in_stall   = (state_r == ST_REPORT);
  assign in_accept  = in_valid & ~in_stall;
  assign out_valid  = out_valid_r;
  assign out_accept = out_valid_r & ~out_stall;

  // Cell command: capture data samples after the reference, shift on taken reports
  always_comb begin
    ctrl         = '0;
    ctrl.capture = in_accept & (state_r == ST_RUN) & have_ref_r & ~in_data.is_tick;
    ctrl.shift   = out_accept & (state_r == ST_REPORT);
  end

  // Row of channel cells; contents move toward cell 0 during the report
  for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
    logic [CLOCK_BITS-1:0] nb_edge;
    logic                  nb_done;
    if (k == CHANNELS - 1) begin : g_tail
      assign nb_edge = '0;
      assign nb_done = 1'b0;
    end else begin : g_body
      assign nb_edge = edge_chain[k+1];
      assign nb_done = done_chain[k+1];
    end
    fetc_cell #(
      .CLOCK_BITS(CLOCK_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .sample_bit    (in_data.sample[k]),
      .prev_bit      (prev_sample_r[k]),
      .clock_in      (sample_clock_r),
      .shift_edge_in (nb_edge),
      .shift_done_in (nb_done),
      .edge_time_r   (edge_chain[k]),
      .done_r        (done_chain[k]),
      .done_nxt      (done_nxt_vec[k])
    );
  end

  // Finished test against the updated seen flags
  assign all_done = &(done_nxt_vec | ~finished_mask_r[CHANNELS-1:0]);

  // Sequence items, registers and the report
  always_comb begin
    state_nxt         = state_r;
    out_valid_nxt     = out_valid_r;
    cnt_nxt           = cnt_r;
    finished_mask_nxt = finished_mask_r;
    timeout_nxt       = timeout_r;
    skip_left_nxt     = skip_left_r;
    have_ref_nxt      = have_ref_r;
    ref_sample_nxt    = ref_sample_r;
    prev_sample_nxt   = prev_sample_r;
    sample_clock_nxt  = sample_clock_r;
    seconds_nxt       = seconds_r;
    timeout_flag_nxt  = timeout_flag_r;
    check             = 1'b0;

    if (in_accept && state_r == ST_RUN) begin
      if (!have_ref_r) begin
        if (!in_data.is_tick) begin
          if (skip_left_r != '0) begin
            skip_left_nxt = skip_left_r - 1'b1;
          end else begin
            have_ref_nxt     = 1'b1;
            ref_sample_nxt   = in_data.sample;
            prev_sample_nxt  = in_data.sample;
            sample_clock_nxt = CLOCK_BITS'(1);
            check            = 1'b1;
          end
        end
      end else if (in_data.is_tick) begin
        if (timeout_r != '0) begin
          if (seconds_r != '1) begin
            seconds_nxt = seconds_r + 1'b1;
          end
          if (seconds_nxt > timeout_r) begin
            timeout_flag_nxt = 1'b1;
          end
          check = 1'b1;
        end
      end else begin
        prev_sample_nxt = in_data.sample;
        if (sample_clock_r != '1) begin
          sample_clock_nxt = sample_clock_r + 1'b1;
        end
        check = 1'b1;
      end
      if (check && (timeout_flag_nxt || all_done)) begin
        state_nxt     = ST_REPORT;
        out_valid_nxt = 1'b1;
        cnt_nxt       = '0;
      end
    end

    // Advance the report on each taken transaction
    if (ctrl.shift) begin
      if (cnt_r == CntW'(CHANNELS - 1)) begin
        state_nxt     = ST_DONE;
        out_valid_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    // Register writes
    if (cfg_we) begin
      case (cfg_idx)
        fetc_pkg::REG_FINISHED_MASK: begin
          finished_mask_nxt = cfg_data;
        end
        fetc_pkg::REG_SKIP_COUNT: begin
          if (!have_ref_r) begin
            skip_left_nxt = cfg_data[SkW-1:0];
          end
        end
        fetc_pkg::REG_TIMEOUT_SECONDS: begin
          timeout_nxt = cfg_data[SecW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Hold state, run state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_RUN;
      out_valid_r     <= 1'b0;
      cnt_r           <= '0;
      finished_mask_r <= '1;
      timeout_r       <= '0;
      skip_left_r     <= '0;
      have_ref_r      <= 1'b0;
      ref_sample_r    <= '0;
      prev_sample_r   <= '0;
      sample_clock_r  <= '0;
      seconds_r       <= '0;
      timeout_flag_r  <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      cnt_r           <= cnt_nxt;
      finished_mask_r <= finished_mask_nxt;
      timeout_r       <= timeout_nxt;
      skip_left_r     <= skip_left_nxt;
      have_ref_r      <= have_ref_nxt;
      ref_sample_r    <= ref_sample_nxt;
      prev_sample_r   <= prev_sample_nxt;
      sample_clock_r  <= sample_clock_nxt;
      seconds_r       <= seconds_nxt;
      timeout_flag_r  <= timeout_flag_nxt;
    end
  end

  // Report transaction: head cell plus run snapshot
  always_comb begin
    out_data              = '0;
    out_data.channel      = fetc_pkg::chan_t'(cnt_r);
    out_data.edge_clock   = fetc_pkg::clk_out_t'(edge_chain[0]);
    out_data.edge_seen    = done_chain[0];
    out_data.first_sample = ref_sample_r;
    out_data.last_sample  = prev_sample_r;
    out_data.end_clock    = fetc_pkg::clk_out_t'(sample_clock_r);
    out_data.timeout_hit  = timeout_flag_r;
    out_data.last         = (cnt_r == CntW'(CHANNELS - 1));
  end

endmodule

`default_nettype wire

// ===== src/fetc_checker.sv =====
// Port-level checks for the first-edge timestamp capture block, with its bind.
`default_nettype none

module fetc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire fetc_pkg::out_item_t out_data
);

  // A stalled report transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("report transaction changed while stalled");

  // No input is taken while the report is out
  a_stall_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input not stalled during report");

  // Report ends after the final transaction
  a_end_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid)
    else $error("report continued after final transaction");

  // Channels come out in order with no gap
  a_channel_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && (out_data.channel == $past(out_data.channel) + 5'd1))
    else $error("report channel did not advance by one");

endmodule

bind first_edge_timestamp_capture fetc_checker u_fetc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== dv/fetc_report_check.sv =====
`timescale 1ns / 100ps
// Checker for the first-edge timestamp capture block: tracks run state, predicts the report.
module fetc_report_check (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire fetc_pkg::in_item_t              in_data,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire fetc_pkg::out_item_t             out_data,
  input  wire logic                            cfg_we,
  input  wire logic [fetc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [fetc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   fail_count,
  output int                                   pending_cnt,
  output int                                   results_seen,
  output logic                                 report_taken
);

  localparam int          NCH       = fetc_pkg::CHANNELS_DEF;
  localparam logic [47:0] CLOCK_TOP = 48'hFFFF_FFFF_FFFF;

  // Register copies
  logic [31:0] need_mask;
  logic [15:0] skip_reg;
  logic [15:0] secs_limit;

  // Run state
  logic [47:0] edge_at [NCH];
  logic [31:0] toggled;
  logic [31:0] prev_level;
  logic [31:0] ref_level;
  logic [47:0] sample_cnt;
  logic [15:0] skip_left;
  logic        have_ref;
  logic [15:0] secs_cnt;
  logic        timeout_q;
  logic        reported;

  fetc_pkg::out_item_t expected_reports [$];

  task automatic clear_run();
    need_mask   = 32'hFFFF_FFFF;
    skip_reg    = '0;
    secs_limit  = '0;
    for (int k = 0; k < NCH; k++) edge_at[k] = '0;
    toggled     = '0;
    prev_level  = '0;
    ref_level   = '0;
    sample_cnt  = '0;
    skip_left   = '0;
    have_ref    = 1'b0;
    secs_cnt    = '0;
    timeout_q   = 1'b0;
    reported    = 1'b0;
  endtask

  // Queue one report transaction per channel, channel 0 first
  task automatic queue_report();
    fetc_pkg::out_item_t e;
    for (int k = 0; k < NCH; k++) begin
      e.channel      = fetc_pkg::chan_t'(k);
      e.edge_clock   = edge_at[k];
      e.edge_seen    = toggled[k];
      e.first_sample = ref_level;
      e.last_sample  = prev_level;
      e.end_clock    = sample_cnt;
      e.timeout_hit  = timeout_q;
      e.last         = (k == NCH - 1);
      expected_reports.push_back(e);
    end
    reported = 1'b1;
  endtask

  // Advance the run state by one accepted input transaction
  task automatic track_item(input fetc_pkg::in_item_t it);
    logic [31:0] fresh;
    if (reported) return;
    if (!have_ref) begin
      if (it.is_tick) return;
      if (skip_left != 0) begin
        skip_left--;
        return;
      end
      have_ref   = 1'b1;
      ref_level  = it.sample;
      prev_level = it.sample;
      sample_cnt = 48'd1;
    end else if (it.is_tick) begin
      if (secs_limit == 0) return;
      if (secs_cnt != 16'hFFFF) secs_cnt++;
      if (secs_cnt > secs_limit) timeout_q = 1'b1;
    end else begin
      fresh = (it.sample ^ prev_level) & ~toggled;
      for (int k = 0; k < NCH; k++) begin
        if (fresh[k]) edge_at[k] = sample_cnt;
      end
      toggled    = toggled | fresh;
      prev_level = it.sample;
      if (sample_cnt != CLOCK_TOP) sample_cnt++;
    end
    if (timeout_q || ((toggled & need_mask) == need_mask)) queue_report();
  endtask

  // Compare one report transaction against the oldest expectation
  task automatic check_result(input fetc_pkg::out_item_t got);
    fetc_pkg::out_item_t e;
    results_seen++;
    if (expected_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected report transaction: ch=%0d edge=%0h seen=%0b", got.channel,
                 got.edge_clock, got.edge_seen);
      return;
    end
    e = expected_reports.pop_front();
    if (got.channel !== e.channel || got.edge_clock !== e.edge_clock ||
        got.edge_seen !== e.edge_seen || got.first_sample !== e.first_sample ||
        got.last_sample !== e.last_sample || got.end_clock !== e.end_clock ||
        got.timeout_hit !== e.timeout_hit || got.last !== e.last) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch exp: ch=%0d edge=%0h seen=%0b first=%h last=%h clk=%0h to=%0b end=%0b",
                 e.channel, e.edge_clock, e.edge_seen, e.first_sample, e.last_sample,
                 e.end_clock, e.timeout_hit, e.last);
        $display("         got: ch=%0d edge=%0h seen=%0b first=%h last=%h clk=%0h to=%0b end=%0b",
                 got.channel, got.edge_clock, got.edge_seen, got.first_sample, got.last_sample,
                 got.end_clock, got.timeout_hit, got.last);
      end
    end
  endtask

  // At each rising edge: check taken reports, mirror register writes, track accepted items
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_run();
      expected_reports.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (cfg_we) begin
        case (cfg_idx)
          fetc_pkg::REG_FINISHED_MASK: need_mask = cfg_data;
          fetc_pkg::REG_SKIP_COUNT: begin
            skip_reg = cfg_data[15:0];
            if (!have_ref) skip_left = skip_reg;
          end
          fetc_pkg::REG_TIMEOUT_SECONDS: secs_limit = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) track_item(in_data);
    end
    pending_cnt  = expected_reports.size();
    report_taken = reported;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the first-edge timestamp capture block: stimulus, stall pattern and verdict.
module tb_top;

  logic                            clk      = 1'b0;
  logic                            rst_n    = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  fetc_pkg::in_item_t              in_data  = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  fetc_pkg::out_item_t             out_data;
  logic                            cfg_we   = 1'b0;
  logic [fetc_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [fetc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int   fail_count;
  int   pending_cnt;
  int   results_seen;
  logic report_taken;

  // Sender and receiver pacing state
  int          burst_left = 0;
  int          items_sent = 0;
  int          seg_left   = 0;
  int          seg_mode   = 0;
  int          hold_left  = 0;
  logic        hold_val   = 1'b0;
  logic [31:0] cur_level  = '0;
  int          quiet_ch   = 3;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  first_edge_timestamp_capture uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  fetc_report_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt),
    .results_seen(results_seen),
    .report_taken(report_taken)
  );

  // Receiver stall: segments of no stall, random stall, and long alternating runs
  always @(negedge clk) begin
    if (seg_left == 0) begin
      seg_mode = $urandom_range(0, 2);
      seg_left = $urandom_range(16, 80);
    end
    seg_left--;
    case (seg_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (hold_left == 0) begin
          hold_left = $urandom_range(1, 8);
          hold_val  = ~hold_val;
        end
        hold_left--;
        out_stall <= hold_val;
      end
    endcase
  end

  // Present one input transaction and hold it until accepted
  task automatic send_item(input logic tick, input logic [31:0] level);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_data.is_tick <= tick;
    in_data.sample  <= level;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  // Drop valid, wait for all report transactions, then let the pipeline drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input fetc_pkg::reg_idx_t idx, input logic [31:0] value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Next data level: often unchanged, else mostly single-channel flips, some full noise, quiet channel held
  function automatic logic [31:0] next_level(input logic [31:0] cur);
    logic [31:0] v;
    int          pick;
    int          roll;
    roll = $urandom_range(0, 99);
    v    = cur;
    if (roll < 3) begin
      v           = $urandom;
      v[quiet_ch] = cur[quiet_ch];
    end else if (roll < 40) begin
      pick = $urandom_range(0, 30);
      if (pick >= quiet_ch) pick++;
      v[pick] = ~v[pick];
    end
    return v;
  endfunction

  task automatic random_reg_write();
    int sel;
    sel = $urandom_range(0, 2);
    case (sel)
      0: write_reg(fetc_pkg::REG_FINISHED_MASK,
                   ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | (32'h1 << quiet_ch)));
      1: write_reg(fetc_pkg::REG_SKIP_COUNT, $urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 3))
          0:       write_reg(fetc_pkg::REG_TIMEOUT_SECONDS, 32'd0);
          1:       write_reg(fetc_pkg::REG_TIMEOUT_SECONDS, 32'd65535);
          default: write_reg(fetc_pkg::REG_TIMEOUT_SECONDS, $urandom_range(1000, 65534));
        endcase
      end
    endcase
  endtask

  initial begin
    int    mode;
    int    k;
    int    before_report;
    string cause;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n    <= 1'b1;
    quiet_ch = $urandom_range(3, 30);

    // Tick ahead of any reference: dropped
    send_item(1'b1, 32'hFFFF_FFFF);

    // Skip count at its top, then reloaded lower before the reference
    write_reg(fetc_pkg::REG_SKIP_COUNT, 32'h0000_FFFF);
    send_item(1'b0, 32'h0000_0000);
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'hAAAA_AAAA);
    send_item(1'b0, 32'h5555_5555);
    send_item(1'b1, $urandom);
    write_reg(fetc_pkg::REG_SKIP_COUNT, 32'd2);
    send_item(1'b0, 32'h1234_5678);
    send_item(1'b0, 32'h8765_4321);

    // Reference sample, then a skip write that must have no effect
    cur_level = 32'hF0F0_F0F0;
    send_item(1'b0, cur_level);
    write_reg(fetc_pkg::REG_SKIP_COUNT, 32'd7);

    // Ticks with the timeout disabled, then counted against the top limit
    send_item(1'b1, $urandom);
    send_item(1'b1, $urandom);
    write_reg(fetc_pkg::REG_TIMEOUT_SECONDS, 32'h0000_FFFF);
    repeat (3) send_item(1'b1, $urandom);

    // First edges on the end channels, a repeat toggle, an unchanged sample
    cur_level[0] = ~cur_level[0];
    send_item(1'b0, cur_level);
    cur_level[31] = ~cur_level[31];
    send_item(1'b0, cur_level);
    cur_level[0] = ~cur_level[0];
    send_item(1'b0, cur_level);
    send_item(1'b0, cur_level);

    // Narrow the finished mask mid-run, then restore it
    write_reg(fetc_pkg::REG_FINISHED_MASK, (32'h1 << quiet_ch) | 32'h1);
    cur_level = cur_level ^ 32'h0000_0006;
    send_item(1'b0, cur_level);
    send_item(1'b1, $urandom);
    write_reg(fetc_pkg::REG_FINISHED_MASK, 32'hFFFF_FFFF);

    // Random capture with the quiet channel held, registers rewritten now and then
    for (k = 0; k < 420; k++) begin
      if (k % 70 == 69) random_reg_write();
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'b1, $urandom);
      end else begin
        cur_level = next_level(cur_level);
        send_item(1'b0, cur_level);
      end
    end

    // Close the run by one of three causes
    mode = $urandom_range(0, 2);
    case (mode)
      0: begin
        cause = "every channel toggled";
        write_reg(fetc_pkg::REG_FINISHED_MASK, 32'hFFFF_FFFF);
        k = quiet_ch;
        do begin
          cur_level[k] = ~cur_level[k];
          send_item(1'b0, cur_level);
          @(negedge clk);
          in_valid <= 1'b0;
          k = (k + 1) % 32;
        end while (!report_taken);
      end
      1: begin
        cause = "timeout";
        write_reg(fetc_pkg::REG_TIMEOUT_SECONDS, 32'd1);
        do begin
          send_item(1'b1, $urandom);
          @(negedge clk);
          in_valid <= 1'b0;
        end while (!report_taken);
      end
      default: begin
        cause = "empty finished mask";
        write_reg(fetc_pkg::REG_FINISHED_MASK, 32'h0000_0000);
        do begin
          cur_level = next_level(cur_level);
          send_item(1'b0, cur_level);
          @(negedge clk);
          in_valid <= 1'b0;
        end while (!report_taken);
      end
    endcase
    before_report = items_sent;

    // Hold off until the whole report is out, then feed traffic that must be dropped
    wait_idle();
    write_reg(fetc_pkg::REG_FINISHED_MASK, 32'h0000_0000);
    write_reg(fetc_pkg::REG_TIMEOUT_SECONDS, 32'd1);
    write_reg(fetc_pkg::REG_SKIP_COUNT, 32'd0);
    repeat (20) send_item(1'($urandom_range(0, 1)), $urandom);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d input transactions, %0d up to the report, closed by %s.",
             items_sent, before_report, cause);
    $display("Checked %0d report transactions with %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== first_edge_timestamp_capture.f =====
src/fetc_pkg.sv
src/fetc_cell.sv
src/first_edge_timestamp_capture.sv
src/fetc_checker.sv
dv/fetc_report_check.sv
dv/tb_top.sv
